>>> hw/rtl/circular_queue_with_search_defines.svh
// Assertion macros used by the back end (cqs_back) of the circular queue.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("circular queue: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("circular queue: next-cycle check failed");

`endif

>>> hw/rtl/cqs_pkg.sv
`default_nettype none

package cqs_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int POS_W  = 4;
    localparam int CAP_W  = 5;
    localparam int CAP_RESET = 16;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd3;

    typedef enum logic [1:0] {
        OP_INS  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TRAV = 2'd2,
        OP_SRCH = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_ELEMENT  = 3'd5
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         position;
        logic                     last;
    } t_result;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_fq;

    function automatic t_result mk_result(input t_status st, input logic [DATA_W-1:0] d,
                                          input logic [POS_W-1:0] pos, input logic lst);
        t_result r;
        r.status   = st;
        r.data     = d;
        r.position = pos;
        r.last     = lst;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cqs_front.sv
`default_nettype none

module cqs_front
    import cqs_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    input  t_item i_item,
    output logic busy,
    output t_fq  o_fq,
    input  wire  i_pop
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_cmd            r_q [QDEPTH];
    logic [QAW-1:0]  r_wr;
    logic [QAW-1:0]  r_rd;
    logic [QCW-1:0]  r_cnt;
    logic [QCW-1:0]  n_cnt;
    logic            push;
    logic            pop;
    t_cmd            cls;

    function automatic t_op classify(input logic [CMD_W-1:0] c);
        t_op op;
        case (c)
            CMD_INSERT:   op = OP_INS;
            CMD_DELETE:   op = OP_DEL;
            CMD_TRAVERSE: op = OP_TRAV;
            CMD_SEARCH:   op = OP_SRCH;
            default:      op = OP_SRCH;
        endcase
        return op;
    endfunction

    assign busy = (r_cnt == QCW'(QDEPTH));
    assign push = start & ~busy;
    assign pop  = i_pop & (r_cnt != '0);

    assign cls.op    = classify(i_item.command);
    assign cls.value = i_item.value;

    assign o_fq.avail = (r_cnt != '0);
    assign o_fq.cmd   = r_q[r_rd];

    always_comb begin
        case ({push, pop})
            2'b10:   n_cnt = QCW'(r_cnt + 1'b1);
            2'b01:   n_cnt = QCW'(r_cnt - 1'b1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= QAW'(r_wr + 1'b1);
            end
            if (pop) begin
                r_rd <= QAW'(r_rd + 1'b1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cqs_back.sv
`default_nettype none
`include "circular_queue_with_search_defines.svh"

module cqs_back
    import cqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_valid,
    input  wire [CAP_W-1:0]  i_cfg_data,
    input  t_fq              i_fq,
    output logic             o_pop,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    logic [DATA_W-1:0] r_slots [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_occ, n_occ;
    logic [CAP_W-1:0]  r_cap;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DATA_W-1:0] r_key, n_key;
    t_op               r_mode, n_mode;
    logic              r_res_valid, n_res_valid;
    t_result           r_res, n_res;

    logic [CW-1:0]     cap;
    logic              we;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     raddr;
    logic [IW-1:0]     ins_slot;
    logic [IW-1:0]     walk_next;
    logic              last_el;

    // Advance one slot, wrapping to slot 0 at the capacity in force.
    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx,
                                                input logic [CW-1:0] c);
        logic [IW:0] n;
        n = (IW+1)'({1'b0, idx} + 1'b1);
        if (n >= (IW+1)'(c)) begin
            return '0;
        end
        return n[IW-1:0];
    endfunction

    always_comb begin
        if (r_cap == '0) begin
            cap = CW'(1);
        end else if (32'(r_cap) > DEPTH) begin
            cap = CW'(DEPTH);
        end else begin
            cap = CW'(r_cap);
        end
    end

    assign ins_slot  = (r_occ == '0) ? '0 : next_slot(r_tail, cap);
    assign walk_next = next_slot(r_idx, cap);
    assign last_el   = (CW'(r_cnt + 1'b1) == r_occ);
    assign raddr     = (r_state == S_WALK) ? walk_next : r_head;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_mode      = r_mode;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_pop       = 1'b0;
        we          = 1'b0;
        waddr       = ins_slot;

        case (r_state)
            S_IDLE: begin
                if (i_fq.avail) begin
                    o_pop       = 1'b1;
                    n_res_valid = 1'b1;
                    case (i_fq.cmd.op)
                        OP_INS: begin
                            if (r_occ >= cap) begin
                                n_res = mk_result(ST_FULL, '0, '0, 1'b1);
                            end else begin
                                if (r_occ == '0) begin
                                    n_head = '0;
                                end
                                n_tail = ins_slot;
                                n_occ  = CW'(r_occ + 1'b1);
                                we     = 1'b1;
                                n_res  = mk_result(ST_DONE, '0, POS_W'(ins_slot), 1'b1);
                            end
                        end
                        OP_DEL: begin
                            if (r_occ == '0) begin
                                n_res = mk_result(ST_EMPTY, '0, '0, 1'b1);
                            end else begin
                                n_occ = CW'(r_occ - 1'b1);
                                if (r_occ == CW'(1)) begin
                                    n_head = '0;
                                    n_tail = '0;
                                end else begin
                                    n_head = next_slot(r_head, cap);
                                end
                                n_res = mk_result(ST_DONE, '0, '0, 1'b1);
                            end
                        end
                        default: begin
                            if (r_occ == '0) begin
                                n_res = mk_result(ST_EMPTY, '0, '0, 1'b1);
                            end else begin
                                // The head slot is being read this cycle.
                                n_res_valid = 1'b0;
                                n_idx       = r_head;
                                n_cnt       = '0;
                                n_key       = i_fq.cmd.value;
                                n_mode      = i_fq.cmd.op;
                                n_state     = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_mode == OP_TRAV) begin
                    n_res_valid = 1'b1;
                    n_res = mk_result(ST_ELEMENT, r_rd_data, POS_W'(r_idx), last_el);
                    if (last_el) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = walk_next;
                        n_cnt = CW'(r_cnt + 1'b1);
                    end
                end else if (r_rd_data == r_key) begin
                    n_res_valid = 1'b1;
                    n_res       = mk_result(ST_FOUND, '0, POS_W'(r_idx), 1'b1);
                    n_state     = S_IDLE;
                end else if (last_el) begin
                    n_res_valid = 1'b1;
                    n_res       = mk_result(ST_NOTFOUND, '0, '0, 1'b1);
                    n_state     = S_IDLE;
                end else begin
                    n_idx = walk_next;
                    n_cnt = CW'(r_cnt + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_slots[waddr] <= i_fq.cmd.value;
        end
        r_rd_data <= r_slots[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_cap       <= CAP_W'(CAP_RESET);
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_key  <= n_key;
        r_mode <= n_mode;
        r_res  <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `CQS_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, 32'(r_occ) <= DEPTH)
    `CQS_ASSERT_IMP(a_walk_nonempty, i_clk, i_rst_n, r_state == S_WALK, r_occ != '0)
    `CQS_ASSERT_NXT(a_trav_emits, i_clk, i_rst_n, r_state == S_WALK && r_mode == OP_TRAV, r_res_valid)
    `CQS_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, r_res_valid && r_res.last, r_state == S_IDLE)

endmodule

`default_nettype wire

>>> hw/rtl/circular_queue_with_search.sv
`default_nettype none
// Ring-buffer queue with a settable capacity and a linear search.
// Commands come in on i_item (command and value) and are taken at a clock
// edge where start is high and busy is low. A two-entry command queue sits
// in front of the execution unit, so busy only rises when both entries wait.
// Results appear on o_result for exactly one cycle, marked by o_result_valid;
// the receiver cannot hold them off and none is ever repeated.
// An insert, a delete or any command on an empty queue gives a single result,
// which the back end registers after taking the command from the command queue.
// Traverse and search read the slot memory one slot per cycle: traverse
// gives one element per cycle from the head on, and a search stops at the
// first match or after the last element. The single read port of the slot
// memory sets that pace.
// The capacity register is written on the cfg channel (always ready); the user
// must do so only while the block is idle, which the block does not enforce.
// Reset empties the queue and sets the capacity to 16; slot data is not cleared.
module circular_queue_with_search
    import cqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_result_valid,
    output t_result          o_result,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire [CAP_W-1:0]  i_cfg_data
);

    t_fq  fq;
    logic pop;

    assign o_cfg_ready = 1'b1;

    cqs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_fq    (fq),
        .i_pop   (pop)
    );

    cqs_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_fq        (fq),
        .o_pop       (pop),
        .o_res_valid (o_result_valid),
        .o_res       (o_result)
    );

endmodule

`default_nettype wire

>>> tb/tb_circular_queue_with_search.sv
`timescale 1ns / 100ps

module tb_circular_queue_with_search;
    import cqs_pkg::*;

    localparam int SLOTS         = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item            i_item;
    logic             o_result_valid;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;

    // Shadow copy of the queue, updated as each item is accepted.
    logic [DATA_W-1:0] ring_mem [SLOTS];
    int unsigned       head_slot;
    int unsigned       tail_slot;
    int unsigned       fill_count;
    logic [CAP_W-1:0]  capacity_reg;

    t_result pending_results [$];
    t_result oldest_result;
    int      error_count = 0;
    int      cycle_count = 0;
    int      sender_idle_pct = 0;

    circular_queue_with_search #(
        .DEPTH (SLOTS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned ring_capacity();
        int unsigned c;
        c = 32'(capacity_reg);
        if (c < 1) c = 1;
        if (c > SLOTS) c = SLOTS;
        return c;
    endfunction

    function automatic int unsigned ring_next(int unsigned idx, int unsigned cap);
        int unsigned n;
        n = (idx % SLOTS) + 1;
        if (n >= cap) n = 0;
        return n;
    endfunction

    function automatic void queue_expected(t_status st, logic [DATA_W-1:0] d,
                                           int unsigned pos, logic lst);
        t_result r;
        r.status   = st;
        r.data     = d;
        r.position = POS_W'(pos);
        r.last     = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_queue_op(t_item it);
        int unsigned cap;
        int unsigned idx;
        int unsigned k;
        bit          hit;
        cap = ring_capacity();
        case (it.command)
            CMD_INSERT: begin
                if (fill_count >= cap) begin
                    queue_expected(ST_FULL, '0, 0, 1'b1);
                end else begin
                    if (fill_count == 0) begin
                        head_slot = 0;
                        tail_slot = 0;
                    end else begin
                        tail_slot = ring_next(tail_slot, cap);
                    end
                    ring_mem[tail_slot % SLOTS] = it.value;
                    fill_count++;
                    queue_expected(ST_DONE, '0, tail_slot, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (fill_count == 0) begin
                    queue_expected(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    fill_count--;
                    if (fill_count == 0) begin
                        head_slot = 0;
                        tail_slot = 0;
                    end else begin
                        head_slot = ring_next(head_slot, cap);
                    end
                    queue_expected(ST_DONE, '0, 0, 1'b1);
                end
            end
            CMD_TRAVERSE: begin
                if (fill_count == 0) begin
                    queue_expected(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    idx = head_slot % SLOTS;
                    for (k = 0; k < fill_count && k < SLOTS; k++) begin
                        queue_expected(ST_ELEMENT, ring_mem[idx], idx, k + 1 == fill_count);
                        idx = ring_next(idx, cap);
                    end
                end
            end
            CMD_SEARCH: begin
                if (fill_count == 0) begin
                    queue_expected(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    hit = 1'b0;
                    idx = head_slot % SLOTS;
                    for (k = 0; k < fill_count && k < SLOTS && !hit; k++) begin
                        if (ring_mem[idx] == it.value) begin
                            hit = 1'b1;
                            queue_expected(ST_FOUND, '0, idx, 1'b1);
                        end else begin
                            idx = ring_next(idx, cap);
                        end
                    end
                    if (!hit) queue_expected(ST_NOTFOUND, '0, 0, 1'b1);
                end
            end
        endcase
    endfunction

    // Results cannot be held off, so every strobe is checked at once.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d data %0d position %0d last %0d",
                       o_result.status, o_result.data, o_result.position, o_result.last);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_result.status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_result.status, o_result.status);
                    error_count++;
                end
                if (o_result.data !== oldest_result.data) begin
                    $error("data: expected %0d, got %0d", oldest_result.data, o_result.data);
                    error_count++;
                end
                if (o_result.position !== oldest_result.position) begin
                    $error("position: expected %0d, got %0d",
                           oldest_result.position, o_result.position);
                    error_count++;
                end
                if (o_result.last !== oldest_result.last) begin
                    $error("last: expected %0d, got %0d", oldest_result.last, o_result.last);
                    error_count++;
                end
            end
        end
    end

    // Start is left high after acceptance; the next call either drops it for a
    // gap or presents the next item at the same falling edge.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
        t_item it;
        it.command = cmd;
        it.value   = val;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predict_queue_op(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        capacity_reg = cap;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        // A small pool makes duplicates, so search must report the first one.
        if (r < 40) return $urandom_range(7);
        return $urandom;
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return 5'd31;
        if (r < 30) return CAP_W'(SLOTS);
        if (r < 40) return CAP_W'($urandom_range(30, 17));
        if (r < 70) return CAP_W'($urandom_range(4, 1));
        return CAP_W'($urandom_range(15, 5));
    endfunction

    task automatic test_empty_queue();
        send_item(CMD_DELETE, 32'hffff_ffff);
        send_item(CMD_TRAVERSE, 32'h8000_0000);
        send_item(CMD_SEARCH, 32'h7fff_ffff);
    endtask

    // A register value of zero acts as a single slot.
    task automatic test_single_slot();
        write_capacity('0);
        send_item(CMD_INSERT, 32'h7fff_ffff);
        send_item(CMD_INSERT, 32'h8000_0000);
        send_item(CMD_DELETE, '0);
        send_item(CMD_TRAVERSE, '0);
    endtask

    // Writes every slot once, so that no later walk can touch a fresh slot.
    task automatic test_fill_all_slots();
        logic [DATA_W-1:0] fill_values [6];
        fill_values = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                        32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa};
        write_capacity(5'd31);
        for (int i = 0; i < SLOTS; i++) begin
            send_item(CMD_INSERT, i < 6 ? fill_values[i] : $urandom);
        end
        send_item(CMD_INSERT, $urandom);
        send_item(CMD_SEARCH, 32'h0000_0000);
        send_item(CMD_TRAVERSE, $urandom);
    endtask

    // Shrinking the ring while it is full makes the walk wrap onto slot zero.
    task automatic test_capacity_shrink_with_data();
        write_capacity(5'd1);
        send_item(CMD_INSERT, $urandom);
        send_item(CMD_SEARCH, 32'h8000_0000);
        send_item(CMD_TRAVERSE, '0);
        send_item(CMD_DELETE, '0);
    endtask

    task automatic test_random_phase(input int idle_pct, input int n_items);
        int unsigned r;
        sender_idle_pct = idle_pct;
        for (int chunk = 0; chunk < 4; chunk++) begin
            write_capacity(pick_capacity());
            for (int i = 0; i < n_items / 4; i++) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    send_item(CMD_INSERT, pick_value());
                end else if (r < 70) begin
                    send_item(CMD_DELETE, $urandom);
                end else if (r < 85) begin
                    send_item(CMD_TRAVERSE, $urandom);
                end else if ($urandom_range(99) < 60) begin
                    send_item(CMD_SEARCH, ring_mem[$urandom_range(SLOTS - 1)]);
                end else begin
                    send_item(CMD_SEARCH, pick_value());
                end
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        capacity_reg = CAP_W'(CAP_RESET);
        head_slot    = 0;
        tail_slot    = 0;
        fill_count   = 0;
        for (int i = 0; i < SLOTS; i++) ring_mem[i] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 29;
        test_empty_queue();
        test_single_slot();
        test_fill_all_slots();
        test_capacity_shrink_with_data();
        test_random_phase(29, 96);
        test_random_phase(72, 96);
        test_random_phase(0, 96);
        wait_drained();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
